### src/lfu_inverted_page_table_assert.svh
// assertion macros shared by the checker of the inverted page table
// needs clk_i and rst_ni in the scope where a macro is used
`ifndef LFU_INVERTED_PAGE_TABLE_ASSERT_SVH
`define LFU_INVERTED_PAGE_TABLE_ASSERT_SVH

// clocked property, switched off while reset is held
`define LIPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// implication checked at every edge
`define LIPT_ASSERT_IMP(lbl, pre, post, msg) \
  `LIPT_ASSERT(lbl, (pre) |-> (post), msg)

`endif

### src/lipt_pkg.sv
// shared types and constants of the inverted page table
// no dependencies
package lipt_pkg;

  localparam int PID_W      = 16;
  localparam int ADDR_W     = 32;
  localparam int AGE_W      = 16;
  localparam int PA_W       = 21;
  localparam int FRAME_OUT_W = 9;
  localparam int OUTCOME_W  = 3;
  localparam int FAULT_W    = 32;

  localparam int FRAMES_DEF      = 512;
  localparam int MAX_PROCS_DEF   = 16;
  localparam int OFFSET_BITS_DEF = 12;
  localparam int REF_BITS_DEF    = 16;

  localparam logic [AGE_W-1:0] AGING_RESET = AGE_W'(250);

  // operation codes
  localparam logic OP_ACCESS = 1'b0;
  localparam logic OP_TERM   = 1'b1;

  // result codes
  localparam logic [OUTCOME_W-1:0] OC_HIT     = 3'd0;
  localparam logic [OUTCOME_W-1:0] OC_FILL    = 3'd1;
  localparam logic [OUTCOME_W-1:0] OC_CLEAN   = 3'd2;
  localparam logic [OUTCOME_W-1:0] OC_DIRTY   = 3'd3;
  localparam logic [OUTCOME_W-1:0] OC_REFUSED = 3'd4;
  localparam logic [OUTCOME_W-1:0] OC_TERM    = 3'd5;

  typedef struct packed {
    logic              op;
    logic [PID_W-1:0]  pid;
    logic [ADDR_W-1:0] address;
    logic              write;
  } lipt_in_t;

  typedef struct packed {
    logic [PA_W-1:0]        phys_addr;
    logic [FRAME_OUT_W-1:0] frame;
    logic [OUTCOME_W-1:0]   outcome;
    logic [FAULT_W-1:0]     clean_faults;
    logic [FAULT_W-1:0]     dirty_faults;
  } lipt_out_t;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic load;
    logic rd;
    logic finish;
  } lipt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic idx_last;
    logic out_free;
  } lipt_sts_t;

endpackage

### src/lipt_ram.sv
// generic single write, single read memory with registered read data
// no dependencies
module lipt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### src/lipt_ctrl.sv
// sequencer of the inverted page table: clearing pass, scan, finish
// depends on lipt_pkg
module lipt_ctrl import lipt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  lipt_sts_t sts_i,
  output lipt_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.idx_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.rd = 1'b1;
        if (sts_i.idx_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### src/lipt_dpath.sv
// datapath: frame memory, scan trackers, process slots, counters, result register
// depends on lipt_pkg and lipt_ram
module lipt_dpath import lipt_pkg::*; #(
  parameter int FRAMES      = FRAMES_DEF,
  parameter int MAX_PROCS   = MAX_PROCS_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF,
  parameter int REF_BITS    = REF_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [AGE_W-1:0] cfg_wdata_i,
  input  lipt_in_t         in_i,
  input  lipt_cmd_t        cmd_i,
  output lipt_sts_t        sts_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output lipt_out_t        out_o
);

  localparam int IDX_W   = $clog2(FRAMES);
  localparam int PAGE_W  = ADDR_W - OFFSET_BITS;
  localparam int ENTRY_W = 2 + REF_BITS + PAGE_W + PID_W;
  localparam int CNT_W   = $clog2(MAX_PROCS + 1);
  localparam logic [REF_BITS-1:0] REF_MAX = '1;

  // entry layout: valid, dirty, count, page, pid
  localparam int PAGE_LO  = PID_W;
  localparam int REF_LO   = PID_W + PAGE_W;
  localparam int DIRTY_B  = REF_LO + REF_BITS;
  localparam int VALID_B  = DIRTY_B + 1;

  // configuration and item registers
  logic [AGE_W-1:0]       aging_q, acc_cnt_q;
  logic                   op_q, wr_q, age_q;
  logic [PID_W-1:0]       pid_q;
  logic [PAGE_W-1:0]      page_q;
  logic [OFFSET_BITS-1:0] off_q;

  // scan state
  logic [IDX_W-1:0]    idx_q, rd_idx_q;
  logic                rd_vld_q;
  logic                hit_q, free_q, min_init_q;
  logic [IDX_W-1:0]    hit_idx_q, free_idx_q, min_idx_q;
  logic [REF_BITS-1:0] hit_ref_q, min_ref_q;
  logic                hit_dirty_q, min_dirty_q;

  // process table and statistics
  logic [PID_W-1:0]   slots_q [MAX_PROCS];
  logic [CNT_W-1:0]   pcount_q;
  logic [FAULT_W-1:0] clean_q, dirty_q;
  logic               out_valid_q;
  lipt_out_t          out_q;

  // memory ports
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

  lipt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (FRAMES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  // fields of the entry coming out of the memory
  logic [PID_W-1:0]    e_pid;
  logic [PAGE_W-1:0]   e_page;
  logic [REF_BITS-1:0] e_ref, e_ref_aged;
  logic                e_dirty, e_valid, term_hit, match;
  logic [ENTRY_W-1:0]  e_back;

  always_comb begin
    e_pid      = ram_rdata[PID_W-1:0];
    e_page     = ram_rdata[REF_LO-1:PAGE_LO];
    e_ref      = ram_rdata[DIRTY_B-1:REF_LO];
    e_dirty    = ram_rdata[DIRTY_B];
    e_valid    = ram_rdata[VALID_B];
    e_ref_aged = age_q ? (e_ref >> 1) : e_ref;
    term_hit   = (op_q == OP_TERM) && (pid_q != '0) && (e_pid == pid_q);
    match      = (op_q == OP_ACCESS) && e_valid && (e_pid == pid_q) && (e_page == page_q);
    e_back     = {e_valid & ~term_hit, e_dirty, e_ref_aged, e_page, e_pid};
  end

  // process table lookup
  logic                 known, free_any, refused, term_slot;
  logic [MAX_PROCS-1:0] reg_sel;

  always_comb begin
    known     = 1'b0;
    free_any  = 1'b0;
    term_slot = 1'b0;
    reg_sel   = '0;
    for (int i = 0; i < MAX_PROCS; i++) begin
      if (slots_q[i] == pid_q) known = 1'b1;
      if (slots_q[i] == pid_q && pid_q != '0) term_slot = 1'b1;
      if (slots_q[i] == '0 && !free_any) begin
        free_any   = 1'b1;
        reg_sel[i] = 1'b1;
      end
    end
    if (pcount_q >= CNT_W'(MAX_PROCS)) free_any = 1'b0;
    refused = (pid_q == '0) || (!known && !free_any);
  end

  // final decision of an access
  logic                do_write, victim_dirty;
  logic [IDX_W-1:0]    tgt_idx;
  logic [ENTRY_W-1:0]  tgt_entry;
  logic [OUTCOME_W-1:0] outcome;
  logic [REF_BITS-1:0] hit_ref_inc;
  logic [63:0]         pa_wide;

  always_comb begin
    hit_ref_inc  = (hit_ref_q == REF_MAX) ? hit_ref_q : hit_ref_q + 1'b1;
    victim_dirty = min_dirty_q;
    tgt_idx      = min_idx_q;
    tgt_entry    = {1'b1, wr_q, {REF_BITS{1'b0}}, page_q, pid_q};
    outcome      = victim_dirty ? OC_DIRTY : OC_CLEAN;
    if (hit_q) begin
      tgt_idx   = hit_idx_q;
      tgt_entry = {1'b1, hit_dirty_q | wr_q, hit_ref_inc, page_q, pid_q};
      outcome   = OC_HIT;
    end else if (free_q) begin
      tgt_idx = free_idx_q;
      outcome = OC_FILL;
    end
    if (op_q == OP_TERM) begin
      outcome = OC_TERM;
    end else if (refused) begin
      outcome = OC_REFUSED;
    end
    do_write = cmd_i.finish && (op_q == OP_ACCESS) && !refused;
    pa_wide  = (64'(tgt_idx) << OFFSET_BITS) | 64'(off_q);
  end

  // memory write selection: clearing pass, scan write-back, final update
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = '0;
    if (cmd_i.clear) begin
      ram_we = 1'b1;
    end else if (rd_vld_q) begin
      ram_we    = age_q || term_hit;
      ram_waddr = rd_idx_q;
      ram_wdata = e_back;
    end else if (do_write) begin
      ram_we    = 1'b1;
      ram_waddr = tgt_idx;
      ram_wdata = tgt_entry;
    end
  end

  // sweep index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.rd;
      if (cmd_i.clear || cmd_i.rd) begin
        idx_q <= sts_o.idx_last ? '0 : idx_q + 1'b1;
      end
    end
  end

  // item latch, aging cadence and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      aging_q   <= AGING_RESET;
      acc_cnt_q <= '0;
      age_q     <= 1'b0;
      op_q      <= OP_ACCESS;
    end else begin
      if (cfg_we_i) aging_q <= cfg_wdata_i;
      if (cmd_i.load) begin
        op_q  <= in_i.op;
        age_q <= 1'b0;
        if (in_i.op == OP_ACCESS) begin
          if (acc_cnt_q + 1'b1 >= aging_q) begin
            acc_cnt_q <= '0;
            age_q     <= 1'b1;
          end else begin
            acc_cnt_q <= acc_cnt_q + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= idx_q;
    if (cmd_i.load) begin
      pid_q  <= in_i.pid;
      page_q <= in_i.address[ADDR_W-1:OFFSET_BITS];
      off_q  <= in_i.address[OFFSET_BITS-1:0];
      wr_q   <= in_i.write;
    end
  end

  // scan trackers: first hit, first free frame, first least count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q      <= 1'b0;
      free_q     <= 1'b0;
      min_init_q <= 1'b0;
    end else if (cmd_i.load) begin
      hit_q      <= 1'b0;
      free_q     <= 1'b0;
      min_init_q <= 1'b0;
    end else if (rd_vld_q) begin
      if (match && !hit_q) hit_q <= 1'b1;
      if (!e_valid && !free_q) free_q <= 1'b1;
      min_init_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      if (match && !hit_q) begin
        hit_idx_q   <= rd_idx_q;
        hit_ref_q   <= e_ref_aged;
        hit_dirty_q <= e_dirty;
      end
      if (!e_valid && !free_q) free_idx_q <= rd_idx_q;
      if (!min_init_q || e_ref_aged < min_ref_q) begin
        min_ref_q   <= e_ref_aged;
        min_idx_q   <= rd_idx_q;
        min_dirty_q <= e_dirty;
      end
    end
  end

  // process slots, fault counters and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_PROCS; i++) slots_q[i] <= '0;
      pcount_q    <= '0;
      clean_q     <= '0;
      dirty_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_ready_i) out_valid_q <= 1'b0;
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
        if (op_q == OP_TERM) begin
          if (term_slot) begin
            for (int i = 0; i < MAX_PROCS; i++) begin
              if (slots_q[i] == pid_q) slots_q[i] <= '0;
            end
            if (pcount_q != '0) pcount_q <= pcount_q - 1'b1;
          end
        end else if (!refused) begin
          if (!known) begin
            for (int i = 0; i < MAX_PROCS; i++) begin
              if (reg_sel[i]) slots_q[i] <= pid_q;
            end
            pcount_q <= pcount_q + 1'b1;
          end
          if (!hit_q && !free_q) begin
            if (victim_dirty) dirty_q <= dirty_q + 1'b1;
            else clean_q <= clean_q + 1'b1;
          end
        end
      end
    end
  end

  logic granted;
  assign granted = (outcome == OC_HIT) || (outcome == OC_FILL) ||
                   (outcome == OC_CLEAN) || (outcome == OC_DIRTY);

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_q.phys_addr    <= granted ? pa_wide[PA_W-1:0] : '0;
      out_q.frame        <= granted ? pa_wide[OFFSET_BITS +: FRAME_OUT_W] & 
                                      FRAME_OUT_W'(64'(tgt_idx)) : '0;
      out_q.outcome      <= outcome;
      out_q.clean_faults <= clean_q +
        FAULT_W'(granted && !hit_q && !free_q && !victim_dirty);
      out_q.dirty_faults <= dirty_q +
        FAULT_W'(granted && !hit_q && !free_q && victim_dirty);
    end
  end

  assign sts_o.idx_last = (idx_q == IDX_W'(FRAMES - 1));
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_o          = out_q;

endmodule

### src/lfu_inverted_page_table.sv
// top level of the lfu inverted page table with aging
// depends on lipt_pkg, lipt_ctrl, lipt_dpath, lipt_ram
//
//  port group  | direction | handshake             | payload
//  cfg         | in        | cfg_we_i              | cfg_wdata_i (aging interval)
//  in          | in        | in_valid_i/in_ready_o | in_i (lipt_in_t)
//  out         | out       | out_valid_o/out_ready_i | out_o (lipt_out_t)
//
// each item passes the accept cycle, then a scan that reads every
// frame entry through the single read port of the frame memory, a drain state for the last
// read data, then an update state that loads the result register
// after reset a clearing pass writes every frame entry, no item taken
// a result waits in the output register; the update cycle stalls while it is held
module lfu_inverted_page_table import lipt_pkg::*; #(
  parameter int FRAMES      = FRAMES_DEF,
  parameter int MAX_PROCS   = MAX_PROCS_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF,
  parameter int REF_BITS    = REF_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [AGE_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  lipt_in_t         in_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output lipt_out_t        out_o
);

  lipt_cmd_t cmd;
  lipt_sts_t sts;

  // sequencer
  lipt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath
  lipt_dpath #(
    .FRAMES      (FRAMES),
    .MAX_PROCS   (MAX_PROCS),
    .OFFSET_BITS (OFFSET_BITS),
    .REF_BITS    (REF_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

### src/lipt_checker.sv
// port level checks of the inverted page table, bound to the top level
// depends on lipt_pkg and lfu_inverted_page_table_assert.svh
`include "lfu_inverted_page_table_assert.svh"

module lipt_checker import lipt_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             cfg_we_i,
  input logic [AGE_W-1:0] cfg_wdata_i,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input lipt_in_t         in_i,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input lipt_out_t        out_o
);

  // a held result beat stays
  `LIPT_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o, "out beat dropped")
  // one item at a time
  `LIPT_ASSERT(a_one_item, in_valid_i && in_ready_o |=> !in_ready_o, "second item taken")
  // outcome code in range
  `LIPT_ASSERT_IMP(a_outcome, out_valid_o, out_o.outcome <= OC_TERM, "bad outcome")
  // refused and terminated beats carry no translation
  `LIPT_ASSERT_IMP(a_no_xlat,
    out_valid_o && (out_o.outcome == OC_REFUSED || out_o.outcome == OC_TERM),
    out_o.phys_addr == '0 && out_o.frame == '0, "translation on refused beat")

endmodule

bind lfu_inverted_page_table lipt_checker u_lipt_checker (.*);

### tb/lfu_inverted_page_table_chk.sv
// checker for the lfu inverted page table: watches both channels and predicts results
// depends on lipt_pkg; the aging interval is mirrored from the configuration port
`timescale 1ns / 1ps
module lfu_inverted_page_table_chk import lipt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [AGE_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  input  logic             in_ready_o,
  input  lipt_in_t         in_i,
  input  logic             out_valid_o,
  input  logic             out_ready_i,
  input  lipt_out_t        out_o,
  output int               fail_count_o,
  output int               pending_o,
  output int               outcome_seen_o [6]
);
  localparam int NFR = FRAMES_DEF;
  localparam int NPR = MAX_PROCS_DEF;
  localparam int OB  = OFFSET_BITS_DEF;
  localparam logic [REF_BITS_DEF-1:0] REF_TOP = '1;

  typedef struct {
    logic [PID_W-1:0]        pid;
    logic [ADDR_W-OB-1:0]    page;
    logic [REF_BITS_DEF-1:0] refs;
    logic                    dirty;
    logic                    valid;
  } pte_t;

  pte_t              pt [NFR];
  logic [PID_W-1:0]  slot [NPR];
  int                nproc;
  logic [AGE_W-1:0]  acc_cnt, age_ival;
  logic [FAULT_W-1:0] n_clean, n_dirty;
  lipt_out_t         xlat_q [$];
  int                fails;

  assign fail_count_o = fails;
  assign pending_o    = xlat_q.size();

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp_v);
    $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, exp_v);
    fails++;
  endtask

  function automatic lipt_out_t mk(input int fr, input logic [OB-1:0] ofs,
                                   input logic [OUTCOME_W-1:0] oc, input logic grant);
    lipt_out_t r;
    logic [63:0] pa;
    pa = (64'(fr) << OB) | 64'(ofs);
    r.phys_addr    = grant ? pa[PA_W-1:0] : '0;
    r.frame        = grant ? FRAME_OUT_W'(fr) : '0;
    r.outcome      = oc;
    r.clean_faults = n_clean;
    r.dirty_faults = n_dirty;
    return r;
  endfunction

  // translate one access or terminate beat, updating the mirrored table
  function automatic lipt_out_t translate(input lipt_in_t b);
    logic [ADDR_W-OB-1:0] pg;
    logic [OB-1:0] ofs;
    logic known, placed;
    int vic;
    pg  = b.address[ADDR_W-1:OB];
    ofs = b.address[OB-1:0];
    if (b.op == OP_TERM) begin
      if (b.pid != 0) begin
        for (int i = 0; i < NFR; i++) if (pt[i].pid == b.pid) pt[i].valid = 1'b0;
        for (int i = 0; i < NPR; i++) if (slot[i] == b.pid) begin
          slot[i] = '0;
          if (nproc > 0) nproc--;
        end
      end
      return mk(0, '0, OC_TERM, 1'b0);
    end
    // aging cadence
    acc_cnt = acc_cnt + 1'b1;
    if (acc_cnt >= age_ival) begin
      acc_cnt = '0;
      for (int i = 0; i < NFR; i++) pt[i].refs = pt[i].refs >> 1;
    end
    if (b.pid == 0) return mk(0, '0, OC_REFUSED, 1'b0);
    known = 1'b0;
    for (int i = 0; i < NPR; i++) if (slot[i] == b.pid) known = 1'b1;
    if (!known) begin
      placed = 1'b0;
      if (nproc < NPR)
        for (int i = 0; i < NPR; i++) if (!placed && slot[i] == 0) begin
          slot[i] = b.pid;
          nproc++;
          placed = 1'b1;
        end
      if (!placed) return mk(0, '0, OC_REFUSED, 1'b0);
    end
    for (int i = 0; i < NFR; i++)
      if (pt[i].valid && pt[i].pid == b.pid && pt[i].page == pg) begin
        if (pt[i].refs != REF_TOP) pt[i].refs++;
        pt[i].dirty = pt[i].dirty | b.write;
        return mk(i, ofs, OC_HIT, 1'b1);
      end
    for (int i = 0; i < NFR; i++)
      if (!pt[i].valid) begin
        pt[i] = '{b.pid, pg, '0, b.write, 1'b1};
        return mk(i, ofs, OC_FILL, 1'b1);
      end
    vic = 0;
    for (int i = 1; i < NFR; i++) if (pt[i].refs < pt[vic].refs) vic = i;
    if (pt[vic].dirty) n_dirty++;
    else n_clean++;
    begin
      logic was_dirty;
      was_dirty = pt[vic].dirty;
      pt[vic] = '{b.pid, pg, '0, b.write, 1'b1};
      return mk(vic, ofs, was_dirty ? OC_DIRTY : OC_CLEAN, 1'b1);
    end
  endfunction

  // reset state, then follow configuration, input and output beats
  always @(posedge clk_i or negedge rst_ni) begin
    lipt_out_t e;
    if (!rst_ni) begin
      for (int i = 0; i < NFR; i++) pt[i] = '{'0, '0, '0, 1'b0, 1'b0};
      for (int i = 0; i < NPR; i++) slot[i] = '0;
      for (int i = 0; i < 6; i++) outcome_seen_o[i] = 0;
      nproc = 0; acc_cnt = '0; n_clean = '0; n_dirty = '0;
      age_ival = AGING_RESET; fails = 0;
      xlat_q.delete();
    end else begin
      if (cfg_we_i) age_ival = cfg_wdata_i;
      if (in_valid_i && in_ready_o) xlat_q.push_back(translate(in_i));
      if (out_valid_o && out_ready_i) begin
        if (xlat_q.size() == 0) begin
          report("unexpected beat", 64'(out_o.outcome), '0);
        end else begin
          e = xlat_q.pop_front();
          if (out_o.outcome < 6) outcome_seen_o[out_o.outcome]++;
          if (out_o.phys_addr !== e.phys_addr)
            report("phys_addr", 64'(out_o.phys_addr), 64'(e.phys_addr));
          if (out_o.frame !== e.frame) report("frame", 64'(out_o.frame), 64'(e.frame));
          if (out_o.outcome !== e.outcome)
            report("outcome", 64'(out_o.outcome), 64'(e.outcome));
          if (out_o.clean_faults !== e.clean_faults)
            report("clean_faults", 64'(out_o.clean_faults), 64'(e.clean_faults));
          if (out_o.dirty_faults !== e.dirty_faults)
            report("dirty_faults", 64'(out_o.dirty_faults), 64'(e.dirty_faults));
        end
      end
    end
  end
endmodule

### tb/lfu_inverted_page_table_tb.sv
// testbench top for the lfu inverted page table: stimulus, idling and verdict
// depends on lipt_pkg, lfu_inverted_page_table and lfu_inverted_page_table_chk
`timescale 1ns / 1ps
module lfu_inverted_page_table_tb;
  import lipt_pkg::*;

  localparam int  N_RAND    = 1130;
  localparam int  CYC_LIMIT = 3_000_000;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [AGE_W-1:0] cfg_wdata_i = '0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  lipt_in_t         in_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  lipt_out_t        out_o;
  int               fail_count, pending;
  int               cycles = 0;
  int               outcome_seen [6];
  int               n_items;
  logic             calm;
  logic [PID_W-1:0] pid_pool [24];

  always #2 clk_i = ~clk_i;

  lfu_inverted_page_table u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_ready_o, .in_i,
    .out_valid_o, .out_ready_i, .out_o
  );

  lfu_inverted_page_table_chk u_chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_ready_o, .in_i,
    .out_valid_o, .out_ready_i, .out_o, .fail_count_o(fail_count), .pending_o(pending),
    .outcome_seen_o(outcome_seen)
  );

  // cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("lfu_inverted_page_table_tb failed");
      $finish;
    end
  end

  // receiver stalls at random, none in calm stretches
  always @(negedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(99) >= 32);
  end

  // one beat: a gap and optional idle, then hold valid until accepted
  task automatic send(input logic op, input logic [PID_W-1:0] pid,
                      input logic [ADDR_W-1:0] addr, input logic wr);
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 32) @(negedge clk_i);
    in_i       <= '{op: op, pid: pid, address: addr, write: wr};
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    n_items++;
  endtask

  // drain, let the block settle, then write the aging interval
  task automatic set_interval(input logic [AGE_W-1:0] v);
    while (pending != 0) @(negedge clk_i);
    repeat (600) @(negedge clk_i);
    cfg_wdata_i <= v;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // random beat; mostly accesses from a small pool of processes on few pages
  task automatic rand_beat();
    logic [PID_W-1:0] p;
    logic [ADDR_W-1:0] a;
    int r;
    r = $urandom_range(99);
    p = pid_pool[$urandom_range(23)];
    a = (($urandom_range(3) == 0 ? ADDR_W'($urandom >> 12) : ADDR_W'($urandom_range(47)))
         << 12) | ADDR_W'($urandom_range(4095));
    if (r < 4) send(OP_TERM, p, $urandom, 1'($urandom_range(1)));
    else if (r < 6) send(OP_ACCESS, '0, $urandom, 1'($urandom_range(1)));
    else if (r < 8) send(OP_ACCESS, PID_W'($urandom), $urandom, 1'($urandom_range(1)));
    else send(OP_ACCESS, p, a, 1'($urandom_range(1)));
  endtask

  initial begin
    n_items = 0; calm = 1'b0;
    for (int i = 0; i < 24; i++) pid_pool[i] = PID_W'(i + 1) | (i[0] ? 16'h8000 : 16'h0);
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, both ops, pid zero, unknown terminate, hits, full table
    send(OP_ACCESS, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    send(OP_ACCESS, 16'hFFFF, 32'hFFFF_F000, 1'b0);
    send(OP_ACCESS, 16'h0001, 32'h0000_0000, 1'b0);
    send(OP_ACCESS, 16'h0001, 32'h0000_0ABC, 1'b1);
    send(OP_ACCESS, '0, 32'h1234_5678, 1'b1);
    send(OP_TERM, '0, 32'hFFFF_FFFF, 1'b1);
    send(OP_TERM, 16'h7777, '0, 1'b0);
    for (int i = 0; i < 16; i++) send(OP_ACCESS, 16'h0100 + PID_W'(i), 32'h5000 << i, 1'b0);
    send(OP_TERM, 16'hFFFF, '0, 1'b0);
    send(OP_TERM, 16'h0001, '0, 1'b0);

    // random phases at several aging intervals, extremes among them
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_interval(16'd1);
        1: set_interval(16'hFFFF);
        2: set_interval(16'd0);
        3: set_interval(16'd7);
        4: set_interval(AGING_RESET);
        default: set_interval(AGE_W'($urandom_range(2, 40)));
      endcase
      calm = (ph == 3);
      for (int k = 0; k < N_RAND / 6; k++) begin
        rand_beat();
        if (ph == 1 && k == 40) while (pending != 0) @(negedge clk_i);
      end
      calm = 1'b0;
    end

    while (pending != 0) @(negedge clk_i);
    repeat (600) @(negedge clk_i);
    $display("%0d beats sent over six aging settings; outcomes hit %0d fill %0d clean %0d",
             n_items, outcome_seen[0], outcome_seen[1], outcome_seen[2]);
    $display("dirty %0d refused %0d terminated %0d", outcome_seen[3], outcome_seen[4],
             outcome_seen[5]);
    if (fail_count == 0) begin
      $display("lfu_inverted_page_table_tb passed");
    end else begin
      $display("lfu_inverted_page_table_tb failed");
    end
    $finish;
  end
endmodule
